@@ src/acclp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package acclp_pkg;
   localparam int MAX_DATA_BYTES = 8;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        is_control;
      logic [1:0]  response_kind;
      logic        opened;
      logic [19:0] bitrate_bps;
      logic        extended;
      logic        remote;
      logic [30:0] identifier;
      logic [3:0]  length_code;
      logic [63:0] payload;
   } rsp_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FORMAT = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;
   localparam logic [1:0] ST_LENGTH = 2'd3;

   localparam logic [1:0] RESP_NONE = 2'd0;
   localparam logic [1:0] RESP_CR = 2'd1;
   localparam logic [1:0] RESP_HW = 2'd2;
   localparam logic [1:0] RESP_SW = 2'd3;

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
      logic       hex_ok;
      logic [3:0] hex_val;
   } cls_type;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      return r;
   endfunction

   function automatic logic [19:0] rate_lookup(input logic [3:0] code);
      logic [19:0] r;
      unique case (code)
         4'd1: r = 20'd20000;
         4'd2: r = 20'd50000;
         4'd3: r = 20'd100000;
         4'd4: r = 20'd125000;
         4'd5: r = 20'd250000;
         4'd6: r = 20'd500000;
         4'd7: r = 20'd800000;
         4'd8: r = 20'd1000000;
         default: r = 20'd10000;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

@@ src/acclp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module acclp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire acclp_pkg::req_type req_data,
   input  wire logic               req_push,
   output logic                    req_full,
   output acclp_pkg::cls_type      q_data,
   output logic                    q_push,
   input  wire logic               q_full
);
   import acclp_pkg::*;
   logic [4:0] hx;
   logic       unused_clk;
   assign unused_clk = clock ^ reset;
   assign hx = hex_decode(req_data.ch);
   assign req_full = q_full;
   assign q_push = req_push;
   always_comb begin
      q_data.ch = req_data.ch;
      q_data.line_end = req_data.line_end;
      q_data.hex_ok = hx[4];
      q_data.hex_val = hx[3:0];
   end
endmodule
`default_nettype wire

@@ src/acclp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module acclp_queue #(
   parameter int DEPTH = acclp_pkg::QUEUE_DEPTH,
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             push,
   output logic                  full,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty,
   input  wire logic             pop
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic do_push, do_pop;
   assign full = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign rd_data = mem_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= wr_data;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (do_pop) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
      end
   end
endmodule
`default_nettype wire

@@ src/acclp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module acclp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire acclp_pkg::cls_type q_data,
   input  wire logic               q_empty,
   output logic                    q_pop,
   output acclp_pkg::rsp_type      o_data,
   output logic                    o_push,
   input  wire logic               o_full
);
   import acclp_pkg::*;
   logic       open_ff, open_in;
   logic [3:0] rate_ff, rate_in;
   logic [4:0] pos_ff, pos_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [4:0] spd_ff, spd_in;
   logic [31:0] id_ff, id_in;
   logic [3:0] dlc_ff, dlc_in;
   logic [63:0] dat_ff, dat_in;
   logic [1:0] err_ff, err_in;
   logic       stop_ff, stop_in;
   logic go, is_frame, ext, rtr;
   logic [4:0] idhex, p, k;
   logic [5:0] need;
   logic [3:0] h;
   logic hok;
   rsp_type r;

   assign go = !q_empty && (!o_full || !q_data.line_end);
   assign q_pop = go;
   assign o_push = go && q_data.line_end;
   assign o_data = r;
   assign is_frame = cmd_ff == "t" || cmd_ff == "r" || cmd_ff == "T" || cmd_ff == "R";
   assign ext = cmd_ff == "T" || cmd_ff == "R";
   assign rtr = cmd_ff == "r" || cmd_ff == "R";
   assign idhex = ext ? 5'd8 : 5'd3;
   assign p = pos_ff;
   assign k = p - idhex - 5'd2;
   assign h = q_data.hex_val;
   assign hok = q_data.hex_ok;
   assign need = 6'(idhex) + 6'd2 + {1'b0, dlc_ff, 1'b0};

   always_comb begin
      open_in = open_ff; rate_in = rate_ff; pos_in = pos_ff; cmd_in = cmd_ff;
      spd_in = spd_ff; id_in = id_ff; dlc_in = dlc_ff; dat_in = dat_ff;
      err_in = err_ff; stop_in = stop_ff;
      r = '0;
      if (!q_data.line_end) begin
         if (!stop_ff) begin
            if (q_data.ch == 8'd0) stop_in = 1'b1;
            else begin
               if (p == 5'd0) cmd_in = q_data.ch;
               else if (p == 5'd1) spd_in = {hok, h};
               if (p != 5'd0 && is_frame && err_ff == ST_OK) begin
                  if (p <= idhex) begin
                     if (!hok || (ext && p == 5'd1 && h[3])) err_in = ST_FORMAT;
                     else id_in = {id_ff[27:0], h};
                  end else if (p == idhex + 5'd1) begin
                     if (!hok || h > 4'(MAX_DATA_BYTES)) err_in = ST_LENGTH;
                     else dlc_in = h;
                  end else if (!rtr && 6'(p) <= need - 6'd1) begin
                     if (!hok) err_in = ST_FORMAT;
                     else if (k < 5'd16) dat_in = dat_ff | ({60'd0, h} << (6'd60 - {k[3:0], 2'b00}));
                  end
               end
               if (pos_ff != 5'd31) pos_in = pos_ff + 5'd1;
            end
         end
      end else begin
         if (p == 5'd0) r.status = ST_FORMAT;
         else if (cmd_ff == "O" || cmd_ff == "C") begin
            open_in = (cmd_ff == "O");
            r.is_control = 1'b1; r.response_kind = RESP_CR;
         end else if (cmd_ff == "S" && p == 5'd2 && spd_ff[4]) begin
            if (spd_ff[3:0] > 4'd8) r.status = ST_UNKNOWN;
            else begin
               rate_in = spd_ff[3:0]; r.is_control = 1'b1; r.response_kind = RESP_CR;
            end
         end else if (cmd_ff == "V" || cmd_ff == "v") begin
            r.is_control = 1'b1;
            r.response_kind = (cmd_ff == "V") ? RESP_HW : RESP_SW;
         end else if (is_frame) begin
            if (err_ff != ST_OK) r.status = err_ff;
            else if (p < idhex + 5'd2) r.status = ST_FORMAT;
            else if (!rtr && 6'(p) < need) r.status = ST_FORMAT;
            else begin
               r.extended = ext; r.remote = rtr; r.identifier = id_ff[30:0];
               r.length_code = dlc_ff; r.payload = rtr ? 64'd0 : dat_ff;
            end
         end else r.status = ST_UNKNOWN;
         r.opened = open_in;
         r.bitrate_bps = rate_lookup(rate_in);
         pos_in = '0; cmd_in = '0; spd_in = '0; id_in = '0; dlc_in = '0;
         dat_in = '0; err_in = ST_OK; stop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0; rate_ff <= '0; pos_ff <= '0; cmd_ff <= '0; spd_ff <= '0;
         id_ff <= '0; dlc_ff <= '0; dat_ff <= '0; err_ff <= ST_OK; stop_ff <= 1'b0;
      end else if (go) begin
         open_ff <= open_in; rate_ff <= rate_in; pos_ff <= pos_in; cmd_ff <= cmd_in;
         spd_ff <= spd_in; id_ff <= id_in; dlc_ff <= dlc_in; dat_ff <= dat_in;
         err_ff <= err_in; stop_ff <= stop_in;
      end
   end
endmodule
`default_nettype wire

@@ src/ascii_can_command_line_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Takes one character per beat and returns one result per line end. Each
// character passes through a classify stage, a two-entry queue and
// the parse stage; results wait in a two-entry output queue, so a beat can be
// accepted every cycle while results are drained.
module ascii_can_command_line_parser #(
   parameter int QUEUE_DEPTH = acclp_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire acclp_pkg::req_type req_data,
   input  wire logic               req_push,
   output logic                    req_full,
   output acclp_pkg::rsp_type      rsp_data,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop
);
   import acclp_pkg::*;
   cls_type f_data, b_data;
   logic f_push, f_full, b_empty, b_pop, o_push, o_full;
   rsp_type o_data;

   acclp_front u_front (.clock, .reset, .req_data, .req_push, .req_full,
      .q_data(f_data), .q_push(f_push), .q_full(f_full));
   acclp_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(cls_type))) u_cq (.clock, .reset,
      .wr_data(f_data), .push(f_push), .full(f_full), .rd_data(b_data),
      .empty(b_empty), .pop(b_pop));
   acclp_back u_back (.clock, .reset, .q_data(b_data), .q_empty(b_empty), .q_pop(b_pop),
      .o_data, .o_push, .o_full);
   acclp_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(rsp_type))) u_rq (.clock, .reset,
      .wr_data(o_data), .push(o_push), .full(o_full), .rd_data(rsp_data),
      .empty(rsp_empty), .pop(rsp_pop));
endmodule
`default_nettype wire

@@ src/acclp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module acclp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire acclp_pkg::rsp_type rsp_data,
   input wire logic               rsp_empty
);
   import acclp_pkg::*;
   a_len: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.length_code <= 4'(MAX_DATA_BYTES)) else $error("dlc");
   a_ctl: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.status != ST_OK |-> !rsp_data.is_control
      && rsp_data.response_kind == RESP_NONE) else $error("ctl");
   a_frm: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.is_control |-> !rsp_data.extended && !rsp_data.remote)
      else $error("frm");
   a_rst: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("rst");
endmodule
bind ascii_can_command_line_parser acclp_checker u_chk (.*);
`default_nettype wire
